// ===== rtl/positional_list_engine_unit_assert.svh =====
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine: next-cycle check failed");

`endif

// ===== rtl/ple_pkg.sv =====
// Types and codes shared by the positional list engine modules.
package ple_pkg;

  // Slot indexes cover the largest supported capacity of 64 entries.
  localparam int SLOT_W = 6;
  localparam int WORD_W = 32;

  localparam logic [2:0] MODE_APPEND     = 3'd0;
  localparam logic [2:0] MODE_INS_FRONT  = 3'd1;
  localparam logic [2:0] MODE_INS_POS    = 3'd2;
  localparam logic [2:0] MODE_DEL_FIRST  = 3'd3;
  localparam logic [2:0] MODE_DEL_LAST   = 3'd4;
  localparam logic [2:0] MODE_DEL_POS    = 3'd5;
  localparam logic [2:0] MODE_COUNT      = 3'd6;
  localparam logic [2:0] MODE_DUMP       = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] tail;
    logic [WORD_W-1:0] value;
  } ple_cell_cmd_t;

endpackage

// ===== rtl/ple_cell.sv =====
// One storage cell of the list chain.
module ple_cell
  import ple_pkg::*;
(
  input  logic                clk,
  input  logic [SLOT_W-1:0]   slot,
  input  ple_cell_cmd_t       cmd,
  input  logic [WORD_W-1:0]   left,
  input  logic [WORD_W-1:0]   right,
  input  logic [WORD_W-1:0]   wrap,
  output logic [WORD_W-1:0]   word
);

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (cmd.op)
      CELL_INS: begin
        if (slot == cmd.idx) begin
          word_next = cmd.value;
        end else if (slot > cmd.idx) begin
          word_next = left;
        end
      end
      CELL_DEL: begin
        if (slot >= cmd.idx) begin
          word_next = right;
        end
      end
      CELL_ROT: begin
        if (slot == cmd.tail) begin
          word_next = wrap;
        end else if (slot < cmd.tail) begin
          word_next = right;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: control, result register and cell chain.
//
// The list lives in a row of CAPACITY cells, one signed 32-bit word each, packed
// from the front at cell 0. Every edit (append, front insert, positional insert
// and the three deletes) is one command broadcast to all cells, which load from
// their left or right neighbour in parallel, so an edit item's single result
// appears in the output register in the cycle after the item is taken. A count
// item behaves the same. For a dump of a list of N entries, the cycle that takes
// the item emits nothing, then the chain rotates N times, one cell-0 word per
// cycle to the output while the output is not stalled, leaving the list in its
// original order. No item is accepted during a dump. A stalled output holds the
// engine, since an item is only taken when the result register is free or being
// emptied in the same cycle. A full list rejects inserts with status full, though
// a positional insert checks its position first; a bad position gives status invalid
// position and a delete or a dump on an empty list gives status empty, all leaving
// the list untouched. The count field carries the element count modulo 64.
`include "positional_list_engine_unit_assert.svh"

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // mode[2:0], position[10:3], value[42:11], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], count[7:2], element[39:8]
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_DUMP = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  dump_k;
  logic [1:0]        out_status;
  logic [5:0]        out_count;
  logic [WORD_W-1:0] out_element;

  logic [2:0]        mode;
  logic [7:0]        position;
  logic [WORD_W-1:0] value;

  logic              out_free;
  logic              accept;
  logic              emit;
  logic              emit_last;
  logic              start_dump;
  logic [1:0]        status_d;
  logic [WORD_W-1:0] element_d;
  logic [CNT_W-1:0]  count_next;
  logic [8:0]        pos9;
  logic [8:0]        cnt9;
  logic              is_full;
  logic              is_empty;
  ple_cell_cmd_t     cmd;

  logic [WORD_W-1:0] words [CAPACITY];

  assign mode     = s_tdata[2:0];
  assign position = s_tdata[10:3];
  assign value    = s_tdata[42:11];

  // An item is taken only between dumps and when the result register can take
  // its result in the same edge.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == STATE_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign pos9     = {1'b0, position};
  assign cnt9     = 9'(count);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    cmd        = '{op: CELL_HOLD, idx: '0, tail: SLOT_W'(count - 1'b1), value: value};
    emit       = 1'b0;
    emit_last  = 1'b1;
    start_dump = 1'b0;
    status_d   = ST_OK;
    element_d  = '0;
    count_next = count;
    if (accept) begin
      emit = 1'b1;
      case (mode)
        MODE_APPEND, MODE_INS_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op     = CELL_INS;
            cmd.idx    = (mode == MODE_APPEND) ? SLOT_W'(count) : '0;
            count_next = count + 1'b1;
          end
        end
        MODE_INS_POS: begin
          if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
            status_d = ST_BADPOS;
          end else if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op     = CELL_INS;
            cmd.idx    = SLOT_W'(position - 8'd1);
            count_next = count + 1'b1;
          end
        end
        MODE_DEL_FIRST, MODE_DEL_LAST: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.op     = CELL_DEL;
            cmd.idx    = (mode == MODE_DEL_FIRST) ? '0 : SLOT_W'(count - 1'b1);
            count_next = count - 1'b1;
          end
        end
        MODE_DEL_POS: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else if (pos9 == 9'd0 || pos9 > cnt9) begin
            status_d = ST_BADPOS;
          end else begin
            cmd.op     = CELL_DEL;
            cmd.idx    = SLOT_W'(position - 8'd1);
            count_next = count - 1'b1;
          end
        end
        MODE_DUMP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            emit       = 1'b0;
            start_dump = 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end else if (state == STATE_DUMP && out_free) begin
      // Rotate the live part of the chain by one so cell 0 shows the next entry.
      cmd.op    = CELL_ROT;
      emit      = 1'b1;
      emit_last = (dump_k == count - 1'b1);
      element_d = words[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_IDLE;
      count    <= '0;
      dump_k   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start_dump) begin
        state  <= STATE_DUMP;
        dump_k <= '0;
      end else if (state == STATE_DUMP && emit) begin
        dump_k <= dump_k + 1'b1;
        if (emit_last) begin
          state <= STATE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status  <= status_d;
      out_count   <= 6'(count_next);
      out_element <= element_d;
      m_tlast     <= emit_last;
    end
  end

  assign m_tdata = {out_element, out_count, out_status};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    ple_cell u_cell (
      .clk   (clk),
      .slot  (SLOT_W'(i)),
      .cmd   (cmd),
      .left  (left_word),
      .right (right_word),
      .wrap  (words[0]),
      .word  (words[i])
    );
  end

  `PLE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `PLE_ASSERT_NOW(a_no_take_in_dump, state == STATE_DUMP, !s_tready)
  `PLE_ASSERT_NEXT(a_dump_count_held, state == STATE_DUMP, $stable(count))
  `PLE_ASSERT_NEXT(a_single_result, accept && mode != MODE_DUMP, m_tvalid && m_tlast)
  `PLE_ASSERT_NEXT(a_dump_ok, state == STATE_DUMP && emit, m_tdata[1:0] == ST_OK)

endmodule

// ===== tb/list_result_monitor.sv =====
// Watches both streams of the list engine, predicts every result and compares it.
module list_result_monitor
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // mode[2:0], position[10:3], value[42:11], zero fill
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // status[1:0], count[7:2], element[39:8]
  input  logic        m_tlast,
  output int          fails,
  output int          outstanding,
  output int          list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  count;
    logic [31:0] element;
    logic        last;
  } list_result_t;

  list_result_t due_results[$];
  logic [31:0]  shadow_words[$];
  int           mismatches = 0;

  assign fails = mismatches;

  task automatic queue_result(input logic [1:0] status, input logic [31:0] element,
                              input logic last);
    list_result_t r;
    r.status  = status;
    r.count   = 6'(shadow_words.size());
    r.element = element;
    r.last    = last;
    due_results.push_back(r);
  endtask

  // Applies one operation to the shadow list and queues the results it causes.
  task automatic apply_list_op(input logic [2:0] mode, input logic [7:0] pos,
                               input logic [31:0] value);
    logic [1:0] status;
    int         len;
    status = ST_OK;
    len    = shadow_words.size();
    case (mode)
      MODE_APPEND, MODE_INS_FRONT: begin
        if (len >= CAPACITY) status = ST_FULL;
        else if (mode == MODE_APPEND) shadow_words.push_back(value);
        else shadow_words.push_front(value);
      end
      MODE_INS_POS: begin
        // The position is checked before the capacity.
        if (pos < 1 || int'(pos) > len + 1) status = ST_BADPOS;
        else if (len >= CAPACITY) status = ST_FULL;
        else shadow_words.insert(int'(pos) - 1, value);
      end
      MODE_DEL_FIRST, MODE_DEL_LAST: begin
        if (len == 0) status = ST_EMPTY;
        else if (mode == MODE_DEL_FIRST) void'(shadow_words.pop_front());
        else void'(shadow_words.pop_back());
      end
      MODE_DEL_POS: begin
        if (len == 0) status = ST_EMPTY;
        else if (pos < 1 || int'(pos) > len) status = ST_BADPOS;
        else shadow_words.delete(int'(pos) - 1);
      end
      MODE_COUNT: ;
      default: begin
        if (len == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < len; i++) begin
            queue_result(ST_OK, shadow_words[i], i == len - 1);
          end
        end
        return;
      end
    endcase
    queue_result(status, '0, 1'b1);
  endtask

  task automatic check_result();
    list_result_t want;
    list_result_t got;
    got = {m_tdata[1:0], m_tdata[7:2], m_tdata[39:8], m_tlast};
    if (due_results.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected result: status %0d count %0d element %0d last %0d",
                 got.status, got.count, $signed(got.element), got.last);
      end
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("mismatch: expected status %0d count %0d element %0d last %0d",
                   want.status, want.count, $signed(want.element), want.last);
          $display("          got      status %0d count %0d element %0d last %0d",
                   got.status, got.count, $signed(got.element), got.last);
        end
        mismatches++;
      end
    end
  endtask

  // A result leaves in the cycle after its item at the earliest, so the output
  // side is checked before the new item is predicted.
  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      shadow_words.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) apply_list_op(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
    end
    outstanding <= due_results.size();
    list_len    <= shadow_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the list engine testbench: clock, reset, stimulus and the verdict.
module testbench
  import ple_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 32;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;

  // Tendencies of a random burst of items.
  localparam int BIAS_GROW   = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_MIXED  = 2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // mode[2:0], position[10:3], value[42:11], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status[1:0], count[7:2], element[39:8]
  logic        m_tlast;

  int fails;
  int outstanding;
  int list_len;

  // Idling percentages of the current phase, and the request for a long
  // hold-off on the output side.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  positional_list_engine_unit #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  list_result_monitor #(.CAPACITY(CAPACITY)) monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fails       (fails),
    .outstanding (outstanding),
    .list_len    (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A hard stop well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Output side. Normally it stalls at random at the rate of the phase; on a
  // hold request it keeps tready low for a long stretch counted here, so that
  // the result register fills and the engine refuses further items.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one item, after a random gap, and returns at the edge at which it
  // was taken. Inputs only change at rising edges, so tready seen at the
  // falling edge is the value that the next rising edge samples.
  task automatic send_item(input logic [2:0] mode, input logic [7:0] pos,
                           input logic [31:0] value);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, pos, mode};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Lowers valid and waits until every predicted result has been seen. The
  // falling edge keeps the read clear of the monitor's own updates.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [2:0] pick_insert();
    case ($urandom_range(2))
      0:       return MODE_APPEND;
      1:       return MODE_INS_FRONT;
      default: return MODE_INS_POS;
    endcase
  endfunction

  function automatic logic [2:0] pick_delete();
    case ($urandom_range(2))
      0:       return MODE_DEL_FIRST;
      1:       return MODE_DEL_LAST;
      default: return MODE_DEL_POS;
    endcase
  endfunction

  // One random item. Growing bursts fill the list up to capacity and beyond,
  // shrinking ones empty it; most positions are in range, the rest span the
  // whole field. The list length is only a guide, the monitor predicts.
  task automatic random_item(input int bias);
    int         roll;
    int         hi;
    logic [2:0] mode;
    logic [7:0] pos;
    roll = $urandom_range(99);
    case (bias)
      BIAS_GROW: begin
        if (roll < 80) mode = pick_insert();
        else if (roll < 90) mode = pick_delete();
        else mode = (roll < 95) ? MODE_COUNT : MODE_DUMP;
      end
      BIAS_SHRINK: begin
        if (roll < 75) mode = pick_delete();
        else if (roll < 90) mode = pick_insert();
        else mode = (roll < 95) ? MODE_COUNT : MODE_DUMP;
      end
      default: mode = 3'($urandom_range(7));
    endcase
    if (mode == MODE_INS_POS) hi = list_len + 1;
    else hi = (list_len == 0) ? 1 : list_len;
    if (hi > 255) hi = 255;
    if ($urandom_range(99) < 75) pos = 8'($urandom_range(hi, 1));
    else pos = 8'($urandom_range(255));
    send_item(mode, pos, $urandom);
  endtask

  // A phase of random bursts under one idling pattern. The last burst is cut
  // short so the phase sends exactly the given number of items.
  task automatic random_phase(input int items, input int idle_pct, input int stall_pct,
                              input int first_burst, input int first_bias);
    int done;
    int burst;
    int bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done  = 0;
    burst = first_burst;
    bias  = first_bias;
    while (done < items) begin
      if (burst > items - done) burst = items - done;
      repeat (burst) begin
        random_item(bias);
        done++;
      end
      burst = $urandom_range(40, 15);
      bias  = $urandom_range(BIAS_MIXED, BIAS_GROW);
    end
    drain();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items: the deletes, a count and a dump on an empty list, positions
    // out of range at both ends, the extreme words, and a dump of a short list.
    send_item(MODE_DUMP,      8'd0,   32'd0);
    send_item(MODE_COUNT,     8'd0,   32'd0);
    send_item(MODE_DEL_FIRST, 8'd0,   32'd0);
    send_item(MODE_DEL_LAST,  8'd0,   32'd0);
    send_item(MODE_DEL_POS,   8'd1,   32'd0);
    send_item(MODE_INS_POS,   8'd0,   32'd5);
    send_item(MODE_INS_POS,   8'd2,   32'd5);
    send_item(MODE_INS_POS,   8'd1,   32'h8000_0000);
    send_item(MODE_APPEND,    8'd255, 32'h7fff_ffff);
    send_item(MODE_INS_FRONT, 8'd0,   32'hffff_ffff);
    send_item(MODE_INS_POS,   8'd255, 32'h1234_5678);
    send_item(MODE_INS_POS,   8'd4,   32'd0);
    send_item(MODE_INS_POS,   8'd2,   32'h5555_aaaa);
    send_item(MODE_DEL_POS,   8'd0,   32'd0);
    send_item(MODE_DEL_POS,   8'd6,   32'd0);
    send_item(MODE_DUMP,      8'd0,   32'd0);
    send_item(MODE_DEL_POS,   8'd2,   32'd0);
    send_item(MODE_DEL_POS,   8'd4,   32'd0);
    send_item(MODE_DEL_FIRST, 8'd0,   32'd0);
    send_item(MODE_DEL_LAST,  8'd0,   32'd0);
    send_item(MODE_COUNT,     8'd0,   32'd0);
    send_item(MODE_DUMP,      8'd0,   32'd0);
    drain();

    // First phase without idling is one long growing burst, so the list
    // reaches capacity and inserts into a full list are tried.
    random_phase(60, 0, 0, 60, BIAS_GROW);

    // Long hold-off on the output while the input keeps offering items.
    hold_req = 1'b1;
    repeat (12) random_item(BIAS_MIXED);
    drain();

    random_phase(60, 67, 0, 30, BIAS_SHRINK);
    random_phase(60, 0, 67, 30, BIAS_GROW);
    random_phase(60, 14, 14, 30, BIAS_MIXED);

    // Room for any result that should not come, such as the tail of a dump.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
